// ===== hdl/idtu_pkg.sv =====
package idtu_pkg;

  localparam logic [1:0] CmdExec  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [7:0] OpHlt  = 8'h76;
  localparam logic [7:0] OpStaxB = 8'h02;
  localparam logic [7:0] OpStaxD = 8'h12;
  localparam logic [7:0] OpLdaxB = 8'h0A;
  localparam logic [7:0] OpLdaxD = 8'h1A;
  localparam logic [7:0] OpSta  = 8'h32;
  localparam logic [7:0] OpLda  = 8'h3A;
  localparam logic [7:0] OpShld = 8'h22;
  localparam logic [7:0] OpLhld = 8'h2A;
  localparam logic [7:0] OpXchg = 8'hEB;
  localparam logic [7:0] OpXthl = 8'hE3;
  localparam logic [7:0] OpPchl = 8'hE9;
  localparam logic [7:0] OpSphl = 8'hF9;

  // one memory access issued by the sequencer
  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  function automatic logic [7:0] pack_psw(input logic [4:0] f);
    return {f[4], f[3], 1'b0, f[2], 1'b0, f[1], 1'b1, f[0]};
  endfunction

  function automatic logic [4:0] unpack_psw(input logic [7:0] p);
    return {p[7], p[6], p[4], p[2], p[0]};
  endfunction

endpackage

// ===== hdl/idtu_mem.sv =====
module idtu_mem
  import idtu_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic     clk_i,
  input  logic     req_valid_i,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [2**MEM_ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      if (req_i.we) begin
        mem_q[req_i.addr[MEM_ADDR_BITS-1:0]] <= req_i.wdata;
      end
      rdata_o <= mem_q[req_i.addr[MEM_ADDR_BITS-1:0]];
    end
  end

endmodule

// ===== hdl/i8080_data_transfer_unit.sv =====
// 8080 data-transfer unit. One word on s_axis carries a command: execute an
// opcode with its immediate, write a memory byte, or read one. The answer on
// m_axis is the register file after the command, the packed flag byte, the read
// byte and an unsupported flag. All bytes go through one single-port memory, one
// access a cycle, under a small sequencer: it decodes the command, issues up to
// four accesses, waits for any read data and then presents the result. The next
// word is taken only after the result has been handed over. Memory holds no
// reset value; reading a byte never written returns whatever is there.
module i8080_data_transfer_unit
  import idtu_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], opcode[9:2], imm[25:10], mem_addr[41:26], mem_data[49:42], pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // reg_a, reg_bc, reg_de, reg_hl, reg_sp, reg_pc, psw_byte, read_data
  output logic [103:0] m_axis_tdata,
  // unsupported
  output logic        m_axis_tuser
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDec  = 3'd1;
  localparam logic [2:0] StAcc  = 3'd2;  // issue access idx
  localparam logic [2:0] StWait = 3'd3;  // read data of last access arrives
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] cmd_q;
  logic [7:0] op_q, mdata_q;
  logic [15:0] imm_q, maddr_q;
  logic [7:0] a_q;
  logic [15:0] bc_q, de_q, hl_q, sp_q, pc_q;
  logic [4:0] f_q;
  logic [7:0] rd_q;
  logic bad_q;
  logic out_valid_q;

  // access plan: up to four accesses, base address, write bytes, read kind
  logic [2:0] nacc_q;        // number of accesses
  logic [1:0] idx_q;
  logic [15:0] base_q;
  logic [3:0] wmask_q;
  logic [7:0] wb_q [4];
  logic [7:0] rb_q [2];      // captured read bytes
  logic [1:0] ridx_q;        // index of read in flight
  logic rpend_q;

  mem_req_t req;
  logic req_valid;
  logic [7:0] mem_rdata;

  idtu_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk_i, .req_valid_i(req_valid), .req_i(req), .rdata_o(mem_rdata)
  );

  // XTHL: reads at 0,1 then writes at 2,3 to sp, sp+1
  always_comb begin
    req.we    = wmask_q[idx_q];
    req.addr  = base_q + {15'd0, idx_q[0]};
    req.wdata = wb_q[idx_q];
    req_valid = (state_q == StAcc);
  end

  logic [1:0] rp;
  logic [7:0] src8;
  logic [15:0] rpv;
  assign rp = op_q[5:4];

  always_comb begin
    case (op_q[2:0])
      3'd0: src8 = bc_q[15:8];
      3'd1: src8 = bc_q[7:0];
      3'd2: src8 = de_q[15:8];
      3'd3: src8 = de_q[7:0];
      3'd4: src8 = hl_q[15:8];
      3'd5: src8 = hl_q[7:0];
      default: src8 = a_q;
    endcase
    case (rp[1:0])
      2'd0: rpv = bc_q;
      2'd1: rpv = de_q;
      2'd2: rpv = hl_q;
      default: rpv = {a_q, pack_psw(f_q)};
    endcase
  end

  logic [15:0] rword;
  assign rword = {rb_q[1], rb_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      a_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0; sp_q <= '0; pc_q <= '0;
      f_q <= '0; rd_q <= '0; bad_q <= 1'b0; out_valid_q <= 1'b0;
      nacc_q <= '0; idx_q <= '0; wmask_q <= '0; rpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rpend_q <= 1'b0;
      if (rpend_q) begin
        rb_q[ridx_q[0]] <= mem_rdata;
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            cmd_q   <= s_axis_tdata[1:0];
            op_q    <= s_axis_tdata[9:2];
            imm_q   <= s_axis_tdata[25:10];
            maddr_q <= s_axis_tdata[41:26];
            mdata_q <= s_axis_tdata[49:42];
          end
        end
        StDec: begin
          rd_q <= '0; bad_q <= 1'b0; nacc_q <= '0; idx_q <= '0;
          wmask_q <= '0;
          if (cmd_q == CmdWrite) begin
            nacc_q <= 3'd1; base_q <= maddr_q; wmask_q <= 4'b0001;
            wb_q[0] <= mdata_q;
          end else if (cmd_q == CmdRead) begin
            nacc_q <= 3'd1; base_q <= maddr_q;
          end else if (cmd_q == CmdExec) begin
            if (op_q[7:6] == 2'b01 && op_q != OpHlt) begin
              if (op_q[5:3] == 3'd6) begin
                nacc_q <= 3'd1; base_q <= hl_q; wmask_q <= 4'b0001;
                wb_q[0] <= src8;
              end else if (op_q[2:0] == 3'd6) begin
                nacc_q <= 3'd1; base_q <= hl_q;
              end else begin
                case (op_q[5:3])
                  3'd0: bc_q[15:8] <= src8;
                  3'd1: bc_q[7:0] <= src8;
                  3'd2: de_q[15:8] <= src8;
                  3'd3: de_q[7:0] <= src8;
                  3'd4: hl_q[15:8] <= src8;
                  3'd5: hl_q[7:0] <= src8;
                  default: a_q <= src8;
                endcase
              end
            end else if ((op_q & 8'hC7) == 8'h06) begin
              case (op_q[5:3])
                3'd0: bc_q[15:8] <= imm_q[7:0];
                3'd1: bc_q[7:0] <= imm_q[7:0];
                3'd2: de_q[15:8] <= imm_q[7:0];
                3'd3: de_q[7:0] <= imm_q[7:0];
                3'd4: hl_q[15:8] <= imm_q[7:0];
                3'd5: hl_q[7:0] <= imm_q[7:0];
                3'd6: begin
                  nacc_q <= 3'd1; base_q <= hl_q; wmask_q <= 4'b0001;
                  wb_q[0] <= imm_q[7:0];
                end
                default: a_q <= imm_q[7:0];
              endcase
            end else if ((op_q & 8'hCF) == 8'h01) begin
              case (rp[1:0])
                2'd0: bc_q <= imm_q;
                2'd1: de_q <= imm_q;
                2'd2: hl_q <= imm_q;
                default: sp_q <= imm_q;
              endcase
            end else if ((op_q & 8'hCF) == 8'hC5) begin
              sp_q <= sp_q - 16'd2; base_q <= sp_q - 16'd2;
              nacc_q <= 3'd2; wmask_q <= 4'b0011;
              wb_q[0] <= rpv[7:0]; wb_q[1] <= rpv[15:8];
            end else if ((op_q & 8'hCF) == 8'hC1) begin
              base_q <= sp_q; nacc_q <= 3'd2;
            end else begin
              case (op_q)
                OpStaxB, OpStaxD, OpSta: begin
                  nacc_q <= 3'd1; wmask_q <= 4'b0001; wb_q[0] <= a_q;
                  base_q <= (op_q == OpStaxB) ? bc_q :
                            (op_q == OpStaxD) ? de_q : imm_q;
                end
                OpLdaxB, OpLdaxD, OpLda: begin
                  nacc_q <= 3'd1;
                  base_q <= (op_q == OpLdaxB) ? bc_q :
                            (op_q == OpLdaxD) ? de_q : imm_q;
                end
                OpShld: begin
                  nacc_q <= 3'd2; wmask_q <= 4'b0011; base_q <= imm_q;
                  wb_q[0] <= hl_q[7:0]; wb_q[1] <= hl_q[15:8];
                end
                OpLhld: begin
                  nacc_q <= 3'd2; base_q <= imm_q;
                end
                OpXchg: begin
                  de_q <= hl_q; hl_q <= de_q;
                end
                OpXthl: begin
                  nacc_q <= 3'd4; wmask_q <= 4'b1100; base_q <= sp_q;
                  wb_q[2] <= hl_q[7:0]; wb_q[3] <= hl_q[15:8];
                end
                OpPchl: pc_q <= hl_q;
                OpSphl: sp_q <= hl_q;
                default: bad_q <= 1'b1;
              endcase
            end
          end
        end
        StAcc: begin
          if (!wmask_q[idx_q]) begin
            rpend_q <= 1'b1; ridx_q <= idx_q;
          end
          idx_q <= idx_q + 2'd1;
        end
        StWait: begin
          // once no read is pending the last byte is in rb_q; commit loads once
          if (!rpend_q) begin
            if (cmd_q == CmdRead) begin
              rd_q <= rb_q[0];
            end else if (cmd_q == CmdExec) begin
              if (op_q[7:6] == 2'b01 && op_q[2:0] == 3'd6) begin
                case (op_q[5:3])
                  3'd0: bc_q[15:8] <= rb_q[0];
                  3'd1: bc_q[7:0] <= rb_q[0];
                  3'd2: de_q[15:8] <= rb_q[0];
                  3'd3: de_q[7:0] <= rb_q[0];
                  3'd4: hl_q[15:8] <= rb_q[0];
                  3'd5: hl_q[7:0] <= rb_q[0];
                  default: a_q <= rb_q[0];
                endcase
              end else if ((op_q & 8'hCF) == 8'hC1) begin
                sp_q <= sp_q + 16'd2;
                case (rp[1:0])
                  2'd0: bc_q <= rword;
                  2'd1: de_q <= rword;
                  2'd2: hl_q <= rword;
                  default: begin
                    a_q <= rb_q[1]; f_q <= unpack_psw(rb_q[0]);
                  end
                endcase
              end else if (op_q == OpLdaxB || op_q == OpLdaxD || op_q == OpLda) begin
                a_q <= rb_q[0];
              end else if (op_q == OpLhld || op_q == OpXthl) begin
                hl_q <= rword;
              end
            end
          end
        end
        StOut: ;
        default: ;
      endcase
      if (state_d == StOut && state_q != StOut) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (s_axis_tvalid) state_d = StDec;
      StDec: begin
        // nacc_q is set in this cycle; peek via decode result next state
        state_d = StAcc;
      end
      StAcc: begin
        if (nacc_q == 3'd0) state_d = StOut;
        else if ({1'b0, idx_q} == nacc_q - 3'd1) state_d = StWait;
      end
      StWait: begin
        // read data lands in the cycle after issue; rb_q captured at this edge
        state_d = rpend_q ? StWait : StOut;
      end
      StOut: if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {rd_q, pack_psw(f_q), pc_q, sp_q, hl_q, de_q, bc_q, a_q};
  assign m_axis_tuser  = bad_q;

endmodule
